// ----- rtl/fle_pkg.sv -----
// shared types and constants for the two-channel lineshape evaluator
`default_nettype none
package fle_pkg;

  localparam int MASS_W  = 24;
  localparam int INT_W   = 32;
  localparam int CFG_W   = 24;
  localparam int CFG_IW  = 3;
  localparam int MUL_CW  = 32;
  localparam int MUL_LAT = 2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_POLE = 3'd0,
    CFG_G1   = 3'd1,
    CFG_M1A  = 3'd2,
    CFG_M1B  = 3'd3,
    CFG_G2   = 3'd4,
    CFG_M2A  = 3'd5,
    CFG_M2B  = 3'd6
  } cfg_idx_e;

endpackage
`default_nettype wire

// ----- rtl/flatte_lineshape_eval.sv -----
// top level of the two-channel lineshape evaluator
//
// input channel: mass_in_i beats qualified by in_valid_i, held off by in_stall_o
// output channel: intensity_o and status_o beats qualified by out_valid_o,
//   held off by out_stall_i; one result beat for every input beat, in order
// configuration: seven 24-bit registers written through cfg_we_i, cfg_idx_i and
//   cfg_data_i, by the user only while no beat is in flight; the block does not enforce it
// throughput: one beat per cycle while in_stall_o is low
// pipeline: a beat passes the bit-serial stages of the squared-momentum divider (98),
//   the square root (49), the mass-ratio divider (99) and the final reciprocal
//   divider (17 + 2*FRAC_BITS)
// the whole pipeline advances on one enable; a skid register behind the output
//   register takes the beat in flight when the receiver stalls, and in_stall_o
//   rises only while that skid register is full
// reset clears all configuration registers and every valid bit, those of the
//   output and skid registers too; no clearing pass is needed
`default_nettype none
module flatte_lineshape_eval
  import fle_pkg::*;
#(
  parameter int FRAC_BITS = 20
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [MASS_W-1:0] mass_in_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [INT_W-1:0]  intensity_o,
  output logic      [1:0]        status_o
);

  localparam int CAP_B = 9 + 2 * FRAC_BITS;
  localparam int RS_W  = 9 + FRAC_BITS;
  localparam int DEN_W = 2 * RS_W + 1;
  localparam int QN_W  = 17 + 2 * FRAC_BITS;
  localparam logic [QN_W-1:0] QNUM = QN_W'(1) << (16 + 2 * FRAC_BITS);

  logic [23:0] pole_q, g1_q, m1a_q, m1b_q, g2_q, m2a_q, m2b_q;
  logic [47:0] ma2_1_q, mb2_1_q, ma2_2_q, mb2_2_q, m2_q;
  logic [24:0] twom;
  logic        en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_q <= '0;
      g1_q   <= '0;
      m1a_q  <= '0;
      m1b_q  <= '0;
      g2_q   <= '0;
      m2a_q  <= '0;
      m2b_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_POLE: pole_q <= cfg_data_i;
        CFG_G1:   g1_q   <= cfg_data_i;
        CFG_M1A:  m1a_q  <= cfg_data_i;
        CFG_M1B:  m1b_q  <= cfg_data_i;
        CFG_G2:   g2_q   <= cfg_data_i;
        CFG_M2A:  m2a_q  <= cfg_data_i;
        CFG_M2B:  m2b_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // squares of the configured masses
  always_ff @(posedge clk_i) begin
    ma2_1_q <= m1a_q * m1a_q;
    mb2_1_q <= m1b_q * m1b_q;
    ma2_2_q <= m2a_q * m2a_q;
    mb2_2_q <= m2b_q * m2b_q;
    m2_q    <= pole_q * pole_q;
  end

  assign twom = {pole_q, 1'b0};

  // input and x^2
  logic [23:0] x0_q, x1_q;
  logic [47:0] s1_q;
  logic        v0_q, v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= mass_in_i;
      x1_q <= x0_q;
      s1_q <= x0_q * x0_q;
    end
  end

  // energy numerators
  logic [48:0] pos1, pos2, num1, num2, num1_q, num2_q;
  logic [47:0] s2_q;
  logic [23:0] x2_q;
  logic        v2_q;

  assign pos1 = 49'(s1_q) + 49'(ma2_1_q);
  assign pos2 = 49'(s1_q) + 49'(ma2_2_q);
  assign num1 = (pos1 >= 49'(mb2_1_q)) ? pos1 - 49'(mb2_1_q) : 49'(mb2_1_q) - pos1;
  assign num2 = (pos2 >= 49'(mb2_2_q)) ? pos2 - 49'(mb2_2_q) : 49'(mb2_2_q) - pos2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num1_q <= num1;
      num2_q <= num2;
      s2_q   <= s1_q;
      x2_q   <= x1_q;
    end
  end

  // squares for q^2
  logic [97:0] a1, b1, a2, b2;
  logic [23:0] x3;
  logic [47:0] s3;
  logic        v3;

  fle_mul #(.WA(49), .WB(49)) u_mul_a1 (
    .clk_i, .en_i(en), .a_i(num1_q), .b_i(num1_q), .p_o(a1)
  );
  fle_mul #(.WA(50), .WB(48)) u_mul_b1 (
    .clk_i, .en_i(en), .a_i({s2_q, 2'b00}), .b_i(ma2_1_q), .p_o(b1)
  );
  fle_mul #(.WA(49), .WB(49)) u_mul_a2 (
    .clk_i, .en_i(en), .a_i(num2_q), .b_i(num2_q), .p_o(a2)
  );
  fle_mul #(.WA(50), .WB(48)) u_mul_b2 (
    .clk_i, .en_i(en), .a_i({s2_q, 2'b00}), .b_i(ma2_2_q), .p_o(b2)
  );
  fle_delay #(.W(72), .D(MUL_LAT)) u_dl_d (
    .clk_i, .rst_ni, .en_i(en), .d_i({x2_q, s2_q}), .q_o({x3, s3})
  );
  fle_delay #(.W(1), .D(MUL_LAT)) u_dv_d (
    .clk_i, .rst_ni, .en_i(en), .d_i(v2_q), .q_o(v3)
  );

  // magnitude of the momentum numerator and its sign
  logic [97:0] t1_q, t2_q;
  logic        r1_q, r2_q, v4_q;
  logic [23:0] x4_q;
  logic [47:0] s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q <= (a1 > b1) ? a1 - b1 : b1 - a1;
      t2_q <= (a2 > b2) ? a2 - b2 : b2 - a2;
      r1_q <= a1 > b1;
      r2_q <= a2 > b2;
      x4_q <= x3;
      s4_q <= s3;
    end
  end

  // q^2 = t / 4x^2
  logic [97:0] q2_1, q2_2;
  logic [23:0] x5;
  logic [47:0] s5;
  logic        r1_5, r2_5, v5;

  fle_div #(.NW(98), .DW(50)) u_div_q1 (
    .clk_i, .en_i(en), .n_i(t1_q), .d_i({s4_q, 2'b00}), .q_o(q2_1)
  );
  fle_div #(.NW(98), .DW(50)) u_div_q2 (
    .clk_i, .en_i(en), .n_i(t2_q), .d_i({s4_q, 2'b00}), .q_o(q2_2)
  );
  fle_delay #(.W(74), .D(98)) u_dl_f (
    .clk_i, .rst_ni, .en_i(en), .d_i({x4_q, s4_q, r1_q, r2_q}), .q_o({x5, s5, r1_5, r2_5})
  );
  fle_delay #(.W(1), .D(98)) u_dv_f (
    .clk_i, .rst_ni, .en_i(en), .d_i(v4_q), .q_o(v5)
  );

  // momentum magnitude
  logic [48:0] rt1, rt2;
  logic [23:0] x6;
  logic [47:0] s6;
  logic        r1_6, r2_6, v6;

  fle_sqrt #(.NW(98)) u_sqrt_1 (.clk_i, .en_i(en), .n_i(q2_1), .r_o(rt1));
  fle_sqrt #(.NW(98)) u_sqrt_2 (.clk_i, .en_i(en), .n_i(q2_2), .r_o(rt2));
  fle_delay #(.W(74), .D(49)) u_dl_g (
    .clk_i, .rst_ni, .en_i(en), .d_i({x5, s5, r1_5, r2_5}), .q_o({x6, s6, r1_6, r2_6})
  );
  fle_delay #(.W(1), .D(49)) u_dv_g (
    .clk_i, .rst_ni, .en_i(en), .d_i(v5), .q_o(v6)
  );

  // channel widths
  logic [72:0] w1, w2;
  logic [23:0] x7;
  logic [47:0] s7;
  logic        r1_7, r2_7, v7;

  fle_mul #(.WA(24), .WB(49)) u_mul_w1 (
    .clk_i, .en_i(en), .a_i(g1_q), .b_i(rt1), .p_o(w1)
  );
  fle_mul #(.WA(24), .WB(49)) u_mul_w2 (
    .clk_i, .en_i(en), .a_i(g2_q), .b_i(rt2), .p_o(w2)
  );
  fle_delay #(.W(74), .D(MUL_LAT)) u_dl_h (
    .clk_i, .rst_ni, .en_i(en), .d_i({x6, s6, r1_6, r2_6}), .q_o({x7, s7, r1_7, r2_7})
  );
  fle_delay #(.W(1), .D(MUL_LAT)) u_dv_h (
    .clk_i, .rst_ni, .en_i(en), .d_i(v6), .q_o(v7)
  );

  // real and imaginary width sums
  logic [73:0] gr_q, gi_q;
  logic [23:0] x8_q;
  logic [47:0] s8_q;
  logic        v8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else if (en) begin
      v8_q <= v7;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gr_q <= 74'(r1_7 ? w1 : 73'd0) + 74'(r2_7 ? w2 : 73'd0);
      gi_q <= 74'(r1_7 ? 73'd0 : w1) + 74'(r2_7 ? 73'd0 : w2);
      x8_q <= x7;
      s8_q <= s7;
    end
  end

  // scale by 2m
  logic [98:0] mgr, mgi;
  logic [23:0] x9;
  logic [47:0] s9;
  logic        v9;

  fle_mul #(.WA(74), .WB(25)) u_mul_kr (
    .clk_i, .en_i(en), .a_i(gr_q), .b_i(twom), .p_o(mgr)
  );
  fle_mul #(.WA(74), .WB(25)) u_mul_ki (
    .clk_i, .en_i(en), .a_i(gi_q), .b_i(twom), .p_o(mgi)
  );
  fle_delay #(.W(72), .D(MUL_LAT)) u_dl_j (
    .clk_i, .rst_ni, .en_i(en), .d_i({x8_q, s8_q}), .q_o({x9, s9})
  );
  fle_delay #(.W(1), .D(MUL_LAT)) u_dv_j (
    .clk_i, .rst_ni, .en_i(en), .d_i(v8_q), .q_o(v9)
  );

  // divide by x
  logic [98:0] kr, ki;
  logic [47:0] s10;
  logic        z10, v10;

  fle_div #(.NW(99), .DW(24)) u_div_kr (
    .clk_i, .en_i(en), .n_i(mgr), .d_i(x9), .q_o(kr)
  );
  fle_div #(.NW(99), .DW(24)) u_div_ki (
    .clk_i, .en_i(en), .n_i(mgi), .d_i(x9), .q_o(ki)
  );
  fle_delay #(.W(49), .D(99)) u_dl_k (
    .clk_i, .rst_ni, .en_i(en), .d_i({s9, x9 == 24'd0}), .q_o({s10, z10})
  );
  fle_delay #(.W(1), .D(99)) u_dv_k (
    .clk_i, .rst_ni, .en_i(en), .d_i(v9), .q_o(v10)
  );

  // denominator components
  logic [99:0]       p_q, re_q;
  logic [98:0]       im11_q, im12_q;
  logic [47:0]       s11_q;
  logic              z11_q, z12_q, z13_q, v11_q, v12_q, v13_q, far13_q;
  logic [RS_W-1:0]   re_s_q, im_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v11_q <= 1'b0;
      v12_q <= 1'b0;
      v13_q <= 1'b0;
    end else if (en) begin
      v11_q <= v10;
      v12_q <= v11_q;
      v13_q <= v12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q     <= 100'(ki) + 100'(m2_q);
      im11_q  <= kr;
      s11_q   <= s10;
      z11_q   <= z10;
      re_q    <= (p_q >= 100'(s11_q)) ? p_q - 100'(s11_q) : 100'(s11_q) - p_q;
      im12_q  <= im11_q;
      z12_q   <= z11_q;
      far13_q <= (|re_q[99:CAP_B]) | (|im12_q[98:CAP_B]);
      re_s_q  <= re_q[CAP_B-1:FRAC_BITS];
      im_s_q  <= im12_q[CAP_B-1:FRAC_BITS];
      z13_q   <= z12_q;
    end
  end

  // |D|^2
  logic [2*RS_W-1:0] re2, im2;
  logic              far14, z14, v14;

  fle_mul #(.WA(RS_W), .WB(RS_W)) u_mul_re (
    .clk_i, .en_i(en), .a_i(re_s_q), .b_i(re_s_q), .p_o(re2)
  );
  fle_mul #(.WA(RS_W), .WB(RS_W)) u_mul_im (
    .clk_i, .en_i(en), .a_i(im_s_q), .b_i(im_s_q), .p_o(im2)
  );
  fle_delay #(.W(2), .D(MUL_LAT)) u_dl_m (
    .clk_i, .rst_ni, .en_i(en), .d_i({far13_q, z13_q}), .q_o({far14, z14})
  );
  fle_delay #(.W(1), .D(MUL_LAT)) u_dv_m (
    .clk_i, .rst_ni, .en_i(en), .d_i(v13_q), .q_o(v14)
  );

  logic [DEN_W-1:0] den_q;
  logic             dz15_q, far15_q, z15_q, v15_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v15_q <= 1'b0;
    end else if (en) begin
      v15_q <= v14;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q   <= DEN_W'(re2) + DEN_W'(im2);
      dz15_q  <= (re2 == '0) && (im2 == '0);
      far15_q <= far14;
      z15_q   <= z14;
    end
  end

  // reciprocal
  logic [QN_W-1:0] quo;
  logic            dz16, far16, z16, v16;

  fle_div #(.NW(QN_W), .DW(DEN_W)) u_div_inv (
    .clk_i, .en_i(en), .n_i(QNUM), .d_i(den_q), .q_o(quo)
  );
  fle_delay #(.W(3), .D(QN_W)) u_dl_o (
    .clk_i, .rst_ni, .en_i(en), .d_i({dz15_q, far15_q, z15_q}), .q_o({dz16, far16, z16})
  );
  fle_delay #(.W(1), .D(QN_W)) u_dv_o (
    .clk_i, .rst_ni, .en_i(en), .d_i(v15_q), .q_o(v16)
  );

  // result selection
  logic [INT_W-1:0] res_int;
  status_e          res_st;
  logic             neg;

  assign neg = g1_q[23] | g2_q[23];

  always_comb begin
    if (neg) begin
      res_int = '0;
      res_st  = ST_NEG;
    end else if (z16) begin
      res_int = '1;
      res_st  = ST_ZERO;
    end else if (far16) begin
      res_int = '0;
      res_st  = ST_OK;
    end else if (dz16 || (|quo[QN_W-1:INT_W])) begin
      res_int = '1;
      res_st  = ST_SAT;
    end else begin
      res_int = quo[INT_W-1:0];
      res_st  = ST_OK;
    end
  end

  // output register with skid
  logic             out_v_q, skid_v_q;
  logic [INT_W-1:0] out_int_q, skid_int_q;
  status_e          out_st_q, skid_st_q;
  logic             out_free;

  assign en       = !skid_v_q;
  assign out_free = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= v16;
      end
    end else if (v16) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_int_q <= skid_int_q;
        out_st_q  <= skid_st_q;
      end else begin
        out_int_q <= res_int;
        out_st_q  <= res_st;
      end
    end else if (en) begin
      skid_int_q <= res_int;
      skid_st_q  <= res_st;
    end
  end

  assign in_stall_o  = skid_v_q;
  assign out_valid_o = out_v_q;
  assign intensity_o = out_int_q;
  assign status_o    = out_st_q;

endmodule
`default_nettype wire

// ----- rtl/fle_mul.sv -----
// two-stage multiplier built from registered partial products
`default_nettype none
module fle_mul
  import fle_pkg::*;
#(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WA-1:0]    a_i,
  input  wire logic [WB-1:0]    b_i,
  output logic      [WA+WB-1:0] p_o
);

  localparam int CW = MUL_CW;
  localparam int NA = (WA + CW - 1) / CW;
  localparam int NB = (WB + CW - 1) / CW;
  localparam int AX = NA * CW;
  localparam int BX = NB * CW;
  localparam int PW = WA + WB;

  logic [AX-1:0]   a_x;
  logic [BX-1:0]   b_x;
  logic [2*CW-1:0] pp_q [NA*NB];
  logic [PW-1:0]   sum_d;
  logic [PW-1:0]   p_q;

  assign a_x = AX'(a_i);
  assign b_x = BX'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i*NB+j] <= a_x[i*CW +: CW] * b_x[j*CW +: CW];
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_d = sum_d + (PW'(pp_q[i*NB+j]) << (CW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_d;
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ----- rtl/fle_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module fle_div #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] n_i,
  input  wire logic [DW-1:0] d_i,
  output logic      [NW-1:0] q_o
);

  logic [DW-1:0] rem_q [NW-1];
  logic [DW-1:0] d_q   [NW-1];
  logic [NW-1:0] nq_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [NW-1:0] n_in;
    logic [DW:0]   tr;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign d_in = d_i;
      assign n_in = n_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = d_q[k-1];
      assign n_in = nq_q[k-1];
    end

    assign tr = {r_in, n_in[NW-1]};
    assign ge = tr >= {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k] <= {n_in[NW-2:0], ge};
      end
    end

    if (k < NW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? DW'(tr - {1'b0, d_in}) : tr[DW-1:0];
          d_q[k]   <= d_in;
        end
      end
    end
  end

  assign q_o = nq_q[NW-1];

endmodule
`default_nettype wire

// ----- rtl/fle_sqrt.sv -----
// pipelined integer square root, one root bit per stage
`default_nettype none
module fle_sqrt #(
  parameter int NW = 32
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [NW-1:0]   n_i,
  output logic      [NW/2-1:0] r_o
);

  localparam int RW  = NW / 2;
  localparam int RMW = RW + 2;

  logic [RMW-1:0] rem_q  [RW-1];
  logic [NW-1:0]  n_q    [RW-1];
  logic [RW-1:0]  root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [RMW-1:0] r_in;
    logic [NW-1:0]  n_in;
    logic [RW-1:0]  rt_in;
    logic [RMW+1:0] tr;
    logic [RMW+1:0] cand;
    logic           ge;

    if (k == 0) begin : g_first
      assign r_in  = '0;
      assign n_in  = n_i;
      assign rt_in = '0;
    end else begin : g_next
      assign r_in  = rem_q[k-1];
      assign n_in  = n_q[k-1];
      assign rt_in = root_q[k-1];
    end

    assign tr   = {r_in, n_in[NW-1:NW-2]};
    assign cand = {2'b00, rt_in, 2'b01};
    assign ge   = tr >= cand;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {rt_in[RW-2:0], ge};
      end
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? RMW'(tr - cand) : RMW'(tr);
          n_q[k]   <= {n_in[NW-3:0], 2'b00};
        end
      end
    end
  end

  assign r_o = root_q[RW-1];

endmodule
`default_nettype wire

// ----- rtl/fle_delay.sv -----
// enable-gated delay line that keeps side data in step with the arithmetic units
`default_nettype none
module fle_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] dl_q [D];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < D; i++) begin
        dl_q[i] <= '0;
      end
    end else if (en_i) begin
      dl_q[0] <= d_i;
      for (int i = 1; i < D; i++) begin
        dl_q[i] <= dl_q[i-1];
      end
    end
  end

  assign q_o = dl_q[D-1];

endmodule
`default_nettype wire

// ----- rtl/fle_chk.sv -----
// port-level checks for the lineshape evaluator, bound to the top level
`default_nettype none
module fle_chk
  import fle_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [INT_W-1:0] intensity_o,
  input wire logic [1:0]       status_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input held off with no output beat pending");

  a_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NEG) |-> (intensity_o == '0))
    else $error("negative coupling beat with nonzero intensity");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_ZERO) || (status_o == ST_SAT)) |-> (intensity_o == '1))
    else $error("saturated beat not at full scale");

endmodule

bind flatte_lineshape_eval fle_chk u_fle_chk (.*);
`default_nettype wire

// ----- bench/tb_top.sv -----
// testbench for flatte_lineshape_eval: directed and random masses checked against a predictor
`timescale 1ns / 1ps
module tb_top;
  import fle_pkg::*;

  localparam int FRAC     = 20;
  localparam int LATENCY  = 281 + 2 * FRAC;
  localparam int LIMIT    = 600000;

  typedef struct packed {
    logic [INT_W-1:0] intensity;
    status_e          status;
  } lineshape_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [MASS_W-1:0] mass_in_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [INT_W-1:0]  intensity_o;
  logic [1:0]        status_o;

  flatte_lineshape_eval #(.FRAC_BITS(FRAC)) dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of the registers
  logic [CFG_W-1:0] pole_m, g_one, m1a, m1b, g_two, m2a, m2b;

  lineshape_t expected_q[$];
  int unsigned cycles, errors, sent, checked, n_sat, n_neg, n_zero, n_ok;
  bit idle_en = 1'b0;
  int unsigned hold_req = 0;

  function automatic logic [127:0] isqrt(logic [127:0] n);
    logic [127:0] r, t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic void add_channel(logic [127:0] s, logic [127:0] ma, logic [127:0] mb,
                                      logic [127:0] g, inout logic [127:0] gr,
                                      inout logic [127:0] gi);
    logic [127:0] ma2, mb2, pos, num, a, b, t, q;
    ma2 = ma * ma;
    mb2 = mb * mb;
    pos = s + ma2;
    num = (pos >= mb2) ? pos - mb2 : mb2 - pos;
    a = num * num;
    b = (s * 4) * ma2;
    t = (a > b) ? a - b : b - a;
    q = isqrt(t / (s * 4));
    if (a > b) gr = gr + g * q;
    else gi = gi + g * q;
  endfunction

  function automatic lineshape_t predict_lineshape(logic [MASS_W-1:0] mass);
    lineshape_t res;
    logic [127:0] x, s, gr, gi, twom, im, p, re, den, quo;
    x = 128'(mass);
    gr = '0;
    gi = '0;
    if (g_one[23] || g_two[23]) begin
      res.intensity = '0; res.status = ST_NEG; return res;
    end
    if (mass == '0) begin
      res.intensity = '1; res.status = ST_ZERO; return res;
    end
    s = x * x;
    add_channel(s, 128'(m1a), 128'(m1b), 128'(g_one), gr, gi);
    add_channel(s, 128'(m2a), 128'(m2b), 128'(g_two), gr, gi);
    twom = 128'(pole_m) * 2;
    im = (gr * twom) / x;
    p = (gi * twom) / x + 128'(pole_m) * 128'(pole_m);
    re = (p >= s) ? p - s : s - p;
    re = re >> FRAC;
    im = im >> FRAC;
    if (re >= (128'd1 << (9 + FRAC)) || im >= (128'd1 << (9 + FRAC))) begin
      res.intensity = '0; res.status = ST_OK; return res;
    end
    den = re * re + im * im;
    if (den == '0) begin
      res.intensity = '1; res.status = ST_SAT; return res;
    end
    quo = (128'd1 << (16 + 2 * FRAC)) / den;
    if (quo > 128'hFFFF_FFFF) begin
      res.intensity = '1; res.status = ST_SAT; return res;
    end
    res.intensity = quo[31:0];
    res.status = ST_OK;
    return res;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // cycle counter and watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** flatte_lineshape_eval: FAILED **");
      $finish;
    end
  end

  // receiver stall generation
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        out_stall_i <= 1'b1;
        hold_req = hold_req - 1;
      end else begin
        out_stall_i <= idle_en && ($urandom_range(0, 99) < 25);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    lineshape_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: intensity %0h status %0d",
               intensity_o, status_o);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        if (intensity_o !== exp_r.intensity) begin
          $error("intensity: expected %0h actual %0h", exp_r.intensity, intensity_o);
          errors++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, status_o);
          errors++;
        end
        case (exp_r.status)
          ST_OK:   n_ok++;
          ST_NEG:  n_neg++;
          ST_ZERO: n_zero++;
          default: n_sat++;
        endcase
      end
    end
  end

  task automatic send_mass(logic [MASS_W-1:0] mass);
    int unsigned gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mass_in_i <= mass;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(predict_lineshape(mass));
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_POLE: pole_m = val;
      CFG_G1:   g_one = val;
      CFG_M1A:  m1a = val;
      CFG_M1B:  m1b = val;
      CFG_G2:   g_two = val;
      CFG_M2A:  m2a = val;
      default:  m2b = val;
    endcase
  endtask

  task automatic load_config(logic [CFG_W-1:0] pm, logic [CFG_W-1:0] g1,
                             logic [CFG_W-1:0] a1, logic [CFG_W-1:0] b1,
                             logic [CFG_W-1:0] g2, logic [CFG_W-1:0] a2,
                             logic [CFG_W-1:0] b2);
    drain();
    write_reg(CFG_POLE, pm);
    write_reg(CFG_G1, g1);
    write_reg(CFG_M1A, a1);
    write_reg(CFG_M1B, b1);
    write_reg(CFG_G2, g2);
    write_reg(CFG_M2A, a2);
    write_reg(CFG_M2B, b2);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // resonance: pole in 0.5..4 GeV, daughters up to pm/2 (ch1) and pm (ch2), modest couplings
  task automatic load_random_physics();
    logic [CFG_W-1:0] pm;
    pm = 24'($urandom_range(24'h08_0000, 24'h40_0000));
    load_config(pm, 24'($urandom_range(0, 24'h0F_FFFF)), 24'($urandom_range(0, pm / 2)),
                24'($urandom_range(0, pm / 2)), 24'($urandom_range(0, 24'h0F_FFFF)),
                24'($urandom_range(0, pm)), 24'($urandom_range(0, pm)));
  endtask

  function automatic logic [MASS_W-1:0] near_pole();
    int signed off;
    off = $signed($urandom_range(0, 24'h02_0000)) - 24'h01_0000;
    if ($urandom_range(0, 3) == 0) off = $signed($urandom_range(0, 64)) - 32;
    return MASS_W'(int'(pole_m) + off);
  endfunction

  task automatic test_reset_state();
    send_mass('0);
    send_mass(24'd1);
    send_mass(24'h10_0000);
    send_mass('1);
  endtask

  task automatic test_negative_coupling();
    load_config(24'h10_0000, 24'h80_0000, 24'h02_0000, 24'h03_0000, 24'h01_0000, 0, 0);
    send_mass(24'h10_0000);
    send_mass('0);
    load_config(24'h10_0000, 24'h01_0000, 24'h02_0000, 24'h03_0000, 24'hFF_FFFF, 0, 0);
    send_mass(24'h0F_0000);
  endtask

  task automatic test_extremes();
    load_config('1, 24'h7F_FFFF, '1, '1, 24'h7F_FFFF, '1, '1);
    send_mass('0);
    send_mass(24'd1);
    send_mass('1);
    send_mass(24'h80_0000);
    load_config(24'h10_0000, 0, 0, 0, 0, 0, 0);
    send_mass(24'h10_0000);
    send_mass(24'h10_0001);
    send_mass(24'h0F_FFFF);
    send_mass(24'h20_0000);
    send_mass(24'd1);
  endtask

  task automatic test_threshold();
    // first-channel daughters summing to the pole: masses at, above and below threshold
    load_config(24'h10_0000, 24'h04_0000, 24'h06_0000, 24'h0A_0000,
                24'h02_0000, 24'h03_0000, 24'h03_0000);
    send_mass(24'h10_0000);
    send_mass(24'h0C_0000);
    send_mass(24'h06_0000);
    send_mass(24'h14_0000);
    send_mass(24'h00_0100);
    send_mass('1);
  endtask

  task automatic test_random(int unsigned phases, int unsigned per_phase);
    int unsigned r;
    for (int ph = 0; ph < phases; ph++) begin
      load_random_physics();
      idle_en = (ph % 4) != 3;
      for (int n = 0; n < per_phase; n++) begin
        r = $urandom_range(0, 9);
        if (r < 7) send_mass(near_pole());
        else if (r < 9) send_mass(MASS_W'($urandom()));
        else send_mass($urandom_range(0, 1) ? '0 : '1);
      end
    end
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    load_random_physics();
    idle_en = 1'b0;
    hold_req = 2 * LATENCY + 300;
    for (int n = 0; n < 500; n++) send_mass(near_pole());
    idle_en = 1'b1;
  endtask

  initial begin
    {pole_m, g_one, m1a, m1b, g_two, m2a, m2b} = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_negative_coupling();
    test_extremes();
    test_threshold();
    test_random(12, 110);
    test_backpressure();
    drain();
    $display("covered %0d masses over many settings, %0d results checked", sent, checked);
    $display("results: %0d ok, %0d negative coupling, %0d mass zero, %0d saturated",
             n_ok, n_neg, n_zero, n_sat);
    if (errors == 0) $display("** flatte_lineshape_eval: PASSED **");
    else $display("** flatte_lineshape_eval: FAILED **");
    $finish;
  end

endmodule
